/* rtl/assert_macros.svh */
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge outside reset
`define AFP_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// antecedent at one edge implies consequent at the next, checked during reset too
`define AFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/afp_pkg.sv */
// shared constants and types of the angle frame parser
`default_nettype none

package afp_pkg;

  localparam int BYTE_W  = 8;
  localparam int ANGLE_W = 16;
  localparam int POS_W   = 3;

  localparam logic [BYTE_W-1:0] HEADER_BYTE  = 8'hAA;
  localparam logic [BYTE_W-1:0] TRAILER_BYTE = 8'h55;

  // frame positions
  localparam logic [POS_W-1:0] POS_IDLE    = 3'd0;
  localparam logic [POS_W-1:0] POS_HEAD_HI = 3'd1;
  localparam logic [POS_W-1:0] POS_HEAD_LO = 3'd2;
  localparam logic [POS_W-1:0] POS_PTCH_HI = 3'd3;
  localparam logic [POS_W-1:0] POS_PTCH_LO = 3'd4;
  localparam logic [POS_W-1:0] POS_ROLL_HI = 3'd5;
  localparam logic [POS_W-1:0] POS_ROLL_LO = 3'd6;
  localparam logic [POS_W-1:0] POS_TRAILER = 3'd7;

  localparam logic [ANGLE_W-1:0] LAST_RESET = '1;

  typedef struct packed {
    logic [ANGLE_W-1:0] heading;
    logic [ANGLE_W-1:0] pitch;
    logic [ANGLE_W-1:0] roll;
    logic               changed;
  } afp_res_t;

  typedef struct packed {
    logic out_vld;
    logic skid_vld;
    logic push;
    logic pop;
  } afp_buf_sts_t;

endpackage

`default_nettype wire

/* rtl/afp_if.sv */
// channel interfaces for received bytes and angle results
`default_nettype none

interface afp_in_if;
  logic                        valid;
  logic                        ready;
  logic [afp_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afp_out_if;
  logic                        valid;
  logic                        ready;
  logic [afp_pkg::ANGLE_W-1:0] heading;
  logic [afp_pkg::ANGLE_W-1:0] pitch;
  logic [afp_pkg::ANGLE_W-1:0] roll;
  logic                        changed;

  modport source (output valid, output heading, output pitch, output roll,
                  output changed, input ready);
  modport sink   (input valid, input heading, input pitch, input roll,
                  input changed, output ready);
endinterface

`default_nettype wire

/* rtl/afp_parser.sv */
// frame position tracking, angle shift registers and change detection
`default_nettype none

module afp_parser (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       byte_vld,
  input  wire logic [afp_pkg::BYTE_W-1:0] byte_in,
  output logic                            res_vld,
  output afp_pkg::afp_res_t               res
);

  logic [afp_pkg::POS_W-1:0]   pos_r,          pos_nxt;
  logic [afp_pkg::ANGLE_W-1:0] heading_r,      heading_nxt;
  logic [afp_pkg::ANGLE_W-1:0] pitch_r,        pitch_nxt;
  logic [afp_pkg::ANGLE_W-1:0] roll_r,         roll_nxt;
  logic [afp_pkg::ANGLE_W-1:0] last_heading_r, last_heading_nxt;
  logic [afp_pkg::ANGLE_W-1:0] last_pitch_r,   last_pitch_nxt;
  logic [afp_pkg::ANGLE_W-1:0] last_roll_r,    last_roll_nxt;

  always_comb begin
    pos_nxt          = pos_r;
    heading_nxt      = heading_r;
    pitch_nxt        = pitch_r;
    roll_nxt         = roll_r;
    last_heading_nxt = last_heading_r;
    last_pitch_nxt   = last_pitch_r;
    last_roll_nxt    = last_roll_r;
    res_vld          = 1'b0;
    if (byte_vld) begin
      case (pos_r) inside
        afp_pkg::POS_IDLE: begin
          if (byte_in == afp_pkg::HEADER_BYTE) begin
            pos_nxt = afp_pkg::POS_HEAD_HI;
          end
        end
        afp_pkg::POS_HEAD_HI, afp_pkg::POS_HEAD_LO: begin
          heading_nxt = {heading_r[afp_pkg::BYTE_W-1:0], byte_in};
          pos_nxt     = pos_r + afp_pkg::POS_W'(1);
        end
        afp_pkg::POS_PTCH_HI, afp_pkg::POS_PTCH_LO: begin
          pitch_nxt = {pitch_r[afp_pkg::BYTE_W-1:0], byte_in};
          pos_nxt   = pos_r + afp_pkg::POS_W'(1);
        end
        afp_pkg::POS_ROLL_HI, afp_pkg::POS_ROLL_LO: begin
          roll_nxt = {roll_r[afp_pkg::BYTE_W-1:0], byte_in};
          pos_nxt  = pos_r + afp_pkg::POS_W'(1);
        end
        default: begin
          // waiting for trailer, other bytes dropped
          if (byte_in == afp_pkg::TRAILER_BYTE) begin
            pos_nxt          = afp_pkg::POS_IDLE;
            res_vld          = 1'b1;
            last_heading_nxt = heading_r;
            last_pitch_nxt   = pitch_r;
            last_roll_nxt    = roll_r;
          end
        end
      endcase
    end
  end

  assign res.heading = heading_r;
  assign res.pitch   = pitch_r;
  assign res.roll    = roll_r;
  assign res.changed = (heading_r != last_heading_r) | (pitch_r != last_pitch_r) |
                       (roll_r != last_roll_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r          <= afp_pkg::POS_IDLE;
      heading_r      <= '0;
      pitch_r        <= '0;
      roll_r         <= '0;
      last_heading_r <= afp_pkg::LAST_RESET;
      last_pitch_r   <= afp_pkg::LAST_RESET;
      last_roll_r    <= afp_pkg::LAST_RESET;
    end else begin
      pos_r          <= pos_nxt;
      heading_r      <= heading_nxt;
      pitch_r        <= pitch_nxt;
      roll_r         <= roll_nxt;
      last_heading_r <= last_heading_nxt;
      last_pitch_r   <= last_pitch_nxt;
      last_roll_r    <= last_roll_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/afp_out_buf.sv */
// result register with skid stage
`default_nettype none

module afp_out_buf (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire afp_pkg::afp_res_t  push_data,
  input  wire logic               pop_rdy,
  output logic                    out_vld,
  output afp_pkg::afp_res_t       out_data,
  output logic                    space_ok,
  output afp_pkg::afp_buf_sts_t   sts
);

  logic              out_vld_r,  out_vld_nxt;
  logic              skid_vld_r, skid_vld_nxt;
  afp_pkg::afp_res_t out_r,      out_nxt;
  afp_pkg::afp_res_t skid_r,     skid_nxt;
  logic              pop;
  logic [1:0]        occ_nxt;

  assign pop = out_vld_r & pop_rdy;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    if (pop) begin
      if (skid_vld_r) begin
        out_nxt      = skid_r;
        skid_vld_nxt = push;
        skid_nxt     = push_data;
      end else begin
        out_vld_nxt = push;
        out_nxt     = push_data;
      end
    end else if (!out_vld_r) begin
      out_vld_nxt = push;
      out_nxt     = push_data;
    end else if (push) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = push_data;
    end
  end

  // room for one more result after this cycle's moves
  assign occ_nxt  = 2'({1'b0, out_vld_r} + {1'b0, skid_vld_r} + {1'b0, push} - {1'b0, pop});
  assign space_ok = (occ_nxt < 2'd2);

  assign out_vld      = out_vld_r;
  assign out_data     = out_r;
  assign sts.out_vld  = out_vld_r;
  assign sts.skid_vld = skid_vld_r;
  assign sts.push     = push;
  assign sts.pop      = pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

/* rtl/angle_frame_parser.sv */
// top level of the angle frame parser
//
// usage
//   in_ch carries one received serial byte per transfer (rx_byte). the parser
//   hunts for header 0xaa, shifts the next six bytes big-endian into heading,
//   pitch and roll, then drops bytes until trailer 0x55 arrives
//   out_ch carries one result per completed frame: the three angles and
//   changed, set when any angle differs from the previous frame's values
//   (all ones after reset)
//   path: a trailer byte accepted on in_ch enters the input register, is
//   parsed in the next cycle, and its result goes to the result register and
//   shows on out_ch, waiting behind earlier results that out_ch still holds
//   throughput: one byte per cycle while in_ch.ready is high, through the parse
//   step between the input register and the result register
//   reset (rst_n low, synchronous) empties the byte and result registers,
//   returns the parser to header hunt and sets the stored angles to all ones
//   when the receiver stalls out_ch, results collect in the result register
//   and a skid stage; in_ch.ready drops once both would be full
`default_nettype none

`include "assert_macros.svh"

module angle_frame_parser (
  input  wire logic  clk,
  input  wire logic  rst_n,
  afp_in_if.sink     in_ch,
  afp_out_if.source  out_ch
);

  // input register
  logic                       byte_vld_r;
  logic [afp_pkg::BYTE_W-1:0] byte_r;
  logic                       in_xfer;

  // parse step to result buffer
  logic                  res_vld;
  afp_pkg::afp_res_t     res;
  afp_pkg::afp_res_t     out_data;
  logic                  space_ok;
  afp_pkg::afp_buf_sts_t buf_sts;

  assign in_ch.ready = space_ok;
  assign in_xfer     = in_ch.valid & in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else begin
      byte_vld_r <= in_xfer;
    end
    byte_r <= in_ch.rx_byte;
  end

  afp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (byte_vld_r),
    .byte_in  (byte_r),
    .res_vld  (res_vld),
    .res      (res)
  );

  afp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .pop_rdy   (out_ch.ready),
    .out_vld   (out_ch.valid),
    .out_data  (out_data),
    .space_ok  (space_ok),
    .sts       (buf_sts)
  );

  assign out_ch.heading = out_data.heading;
  assign out_ch.pitch   = out_data.pitch;
  assign out_ch.roll    = out_data.roll;
  assign out_ch.changed = out_data.changed;

  // skid entry only exists behind a full result register
  `AFP_ASSERT_ALWAYS(a_skid_behind_out, !buf_sts.skid_vld || buf_sts.out_vld)
  // a new result never arrives while both entries stay occupied
  `AFP_ASSERT_ALWAYS(a_no_overflow, !(buf_sts.push && buf_sts.skid_vld && !buf_sts.pop))
  // reset leaves no result pending
  `AFP_ASSERT_NEXT(a_reset_empty, !rst_n, !out_ch.valid && !byte_vld_r)

endmodule

`default_nettype wire
